// ----- rtl/phcf_pkg.sv -----
// Shared types and constants for the packet header capture filter.
`default_nettype none

package phcf_pkg;

  // Largest number of bytes handed to the capture buffer per frame.
  localparam int unsigned CAPTURE_LIMIT = 1536;
  localparam logic [15:0] CAP_LIMIT_W   = 16'(CAPTURE_LIMIT);

  // Number of drop counters, one for each drop verdict.
  localparam int unsigned NUM_DROP_CNT = 6;

  // Header positions within the frame.
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL      = 16'd14;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_DADDR_LO = 16'd30;
  localparam logic [15:0] POS_DADDR_HI = 16'd33;
  localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
  localparam logic [15:0] MIN_IP_LEN   = 16'd34;
  localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [3:0]  MIN_IHL      = 4'd5;

  // Configuration register reset values.
  localparam logic [31:0] RST_METADATA_ADDR  = 32'hA9FEA9FE;
  localparam logic [15:0] RST_DNS_PORT       = 16'd53;
  localparam logic [15:0] RST_VXLAN_DST_PORT = 16'd4789;
  localparam logic [15:0] RST_VXLAN_SRC_PORT = 16'd16401;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    CFG_METADATA_ADDR  = 8'd0,
    CFG_DNS_PORT       = 8'd1,
    CFG_VXLAN_DST_PORT = 8'd2,
    CFG_VXLAN_SRC_PORT = 8'd3
  } cfg_reg_e;

  // Frame verdicts, in check priority order after the captured case.
  typedef enum logic [2:0] {
    VERDICT_CAPTURED  = 3'd0,
    VERDICT_BAD_HDR   = 3'd1,
    VERDICT_NON_IPV4  = 3'd2,
    VERDICT_METADATA  = 3'd3,
    VERDICT_NON_L4    = 3'd4,
    VERDICT_DNS       = 3'd5,
    VERDICT_VXLAN     = 3'd6,
    VERDICT_RING_FULL = 3'd7
  } verdict_e;

  // One input beat.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        ingress;
    logic [31:0] interface_index;
    logic        ring_full;
  } phcf_in_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] wire_length;
    logic [10:0] capture_length;
    logic        direction_out;
    logic [31:0] interface_out;
    logic [63:0] reason_count;
  } phcf_out_t;

  // Header fields of a frame as they stand after its current byte.
  typedef struct packed {
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] dest_address;
    logic [15:0] udp_source;
    logic [15:0] udp_dest;
    logic [15:0] wire_length;
  } phcf_hdr_t;

endpackage

`default_nettype wire

// ----- rtl/packet_header_capture_filter.sv -----
// Top level of the packet header capture filter.
// The filter takes a frame one byte per beat and accepts a byte in every cycle
// that the result side keeps up. Header fields are captured as bytes pass; the
// last byte of a frame loads a judge register, and from there the verdict,
// lengths and updated drop counter move into the output register as soon as
// that register is empty or its result is being taken; the result is offered
// from the output register. The judge and output registers give one beat of
// slack, so a stalled result side holds off new bytes only once both are full.
// Drop counters are 64-bit and wrap; there is no clearing pass after reset.
`default_nettype none

module packet_header_capture_filter (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire phcf_pkg::phcf_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output phcf_pkg::phcf_out_t       out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [7:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  logic                  in_acc;
  phcf_pkg::phcf_hdr_t   hdr_next;

  logic                  j_valid_q;
  phcf_pkg::phcf_hdr_t   j_hdr_q;
  logic                  j_ingress_q;
  logic [31:0]           j_iface_q;
  logic                  j_full_q;
  logic                  j_adv;

  logic                  out_valid_q;
  phcf_pkg::phcf_out_t   out_q;

  logic [31:0]           meta_addr_q;
  logic [15:0]           dns_port_q;
  logic [15:0]           vx_dst_q;
  logic [15:0]           vx_src_q;

  logic [63:0]           cnt_q [phcf_pkg::NUM_DROP_CNT];
  phcf_pkg::verdict_e    verdict;
  logic                  is_drop;
  logic [2:0]            cnt_idx;
  logic [63:0]           cnt_cur;
  logic [63:0]           cnt_inc;
  logic [10:0]           cap_len;
  logic [15:0]           udp_end;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_addr_q <= phcf_pkg::RST_METADATA_ADDR;
      dns_port_q  <= phcf_pkg::RST_DNS_PORT;
      vx_dst_q    <= phcf_pkg::RST_VXLAN_DST_PORT;
      vx_src_q    <= phcf_pkg::RST_VXLAN_SRC_PORT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        phcf_pkg::CFG_METADATA_ADDR:  meta_addr_q <= cfg_data_i;
        phcf_pkg::CFG_DNS_PORT:       dns_port_q  <= cfg_data_i[15:0];
        phcf_pkg::CFG_VXLAN_DST_PORT: vx_dst_q    <= cfg_data_i[15:0];
        phcf_pkg::CFG_VXLAN_SRC_PORT: vx_src_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: the judge stage drains into the output register.
  assign j_adv      = j_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !j_valid_q || j_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  phcf_hdr_capture u_hdr_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (in_data_i.data_byte),
    .last_i   (in_data_i.last_byte),
    .hdr_o    (hdr_next)
  );

  // Judge register: header snapshot of a finished frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_valid_q <= 1'b0;
    end else if (in_acc && in_data_i.last_byte) begin
      j_valid_q <= 1'b1;
    end else if (j_adv) begin
      j_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.last_byte) begin
      j_hdr_q     <= hdr_next;
      j_ingress_q <= in_data_i.ingress;
      j_iface_q   <= in_data_i.interface_index;
      j_full_q    <= in_data_i.ring_full;
    end
  end

  // Verdict checks in priority order.
  always_comb begin
    udp_end = phcf_pkg::ETH_HDR_LEN + {10'b0, j_hdr_q.header_words, 2'b00}
              + phcf_pkg::UDP_HDR_LEN;
    if (j_hdr_q.wire_length < phcf_pkg::ETH_HDR_LEN) begin
      verdict = phcf_pkg::VERDICT_BAD_HDR;
    end else if (j_hdr_q.ether_type != phcf_pkg::ETYPE_IPV4) begin
      verdict = phcf_pkg::VERDICT_NON_IPV4;
    end else if (j_hdr_q.wire_length < phcf_pkg::MIN_IP_LEN) begin
      verdict = phcf_pkg::VERDICT_BAD_HDR;
    end else if (j_hdr_q.dest_address == meta_addr_q) begin
      verdict = phcf_pkg::VERDICT_METADATA;
    end else if (j_hdr_q.header_words < phcf_pkg::MIN_IHL) begin
      verdict = phcf_pkg::VERDICT_BAD_HDR;
    end else if (j_hdr_q.ip_protocol != phcf_pkg::PROTO_TCP &&
                 j_hdr_q.ip_protocol != phcf_pkg::PROTO_UDP) begin
      verdict = phcf_pkg::VERDICT_NON_L4;
    end else if (j_hdr_q.ip_protocol == phcf_pkg::PROTO_UDP &&
                 j_hdr_q.wire_length < udp_end) begin
      verdict = phcf_pkg::VERDICT_BAD_HDR;
    end else if (j_hdr_q.ip_protocol == phcf_pkg::PROTO_UDP &&
                 (j_hdr_q.udp_source == dns_port_q ||
                  j_hdr_q.udp_dest == dns_port_q)) begin
      verdict = phcf_pkg::VERDICT_DNS;
    end else if (j_hdr_q.ip_protocol == phcf_pkg::PROTO_UDP &&
                 (j_hdr_q.udp_source == vx_src_q ||
                  j_hdr_q.udp_dest == vx_dst_q)) begin
      verdict = phcf_pkg::VERDICT_VXLAN;
    end else if (j_full_q) begin
      verdict = phcf_pkg::VERDICT_RING_FULL;
    end else begin
      verdict = phcf_pkg::VERDICT_CAPTURED;
    end
  end

  // Drop counter select and increment.
  always_comb begin
    is_drop = (verdict >= phcf_pkg::VERDICT_NON_IPV4);
    cnt_idx = 3'(verdict) - 3'(phcf_pkg::VERDICT_NON_IPV4);
    cnt_cur = '0;
    for (int i = 0; i < phcf_pkg::NUM_DROP_CNT; i++) begin
      if (cnt_idx == 3'(i)) begin
        cnt_cur = cnt_q[i];
      end
    end
    cnt_inc = cnt_cur + 64'd1;
    cap_len = (j_hdr_q.wire_length > phcf_pkg::CAP_LIMIT_W) ?
              phcf_pkg::CAP_LIMIT_W[10:0] : j_hdr_q.wire_length[10:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < phcf_pkg::NUM_DROP_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (j_adv && is_drop) begin
      for (int i = 0; i < phcf_pkg::NUM_DROP_CNT; i++) begin
        if (cnt_idx == 3'(i)) begin
          cnt_q[i] <= cnt_inc;
        end
      end
    end
  end

  // Output register holds one result beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (j_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (j_adv) begin
      out_q.verdict        <= 3'(verdict);
      out_q.wire_length    <= j_hdr_q.wire_length;
      out_q.capture_length <= cap_len;
      out_q.direction_out  <= j_ingress_q;
      out_q.interface_out  <= j_iface_q;
      out_q.reason_count   <= is_drop ? cnt_inc : 64'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result that is not a drop carries a zero count.
  a_no_count_on_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.verdict < 3'(phcf_pkg::VERDICT_NON_IPV4)
      |-> out_q.reason_count == 64'd0)
    else $error("nonzero count on a pass verdict");

  // The last byte of a frame always lands in the judge register.
  a_last_loads_judge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_byte |=> j_valid_q)
    else $error("last byte did not load the judge stage");

  // A drop result carries a count of at least one, unless its counter has just wrapped.
  a_drop_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_adv && is_drop |=> out_valid_q && out_q.reason_count != 64'd0
      || $past(cnt_cur) == 64'hFFFF_FFFF_FFFF_FFFF)
    else $error("drop result with zero count");

  // Capture length never exceeds the wire length.
  a_cap_le_wire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> {5'b0, out_q.capture_length} <= out_q.wire_length)
    else $error("capture length above wire length");

endmodule

`default_nettype wire

// ----- rtl/phcf_hdr_capture.sv -----
// Byte position tracking and header field capture for one frame at a time.
`default_nettype none

module phcf_hdr_capture (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  output phcf_pkg::phcf_hdr_t     hdr_o
);

  logic [15:0] pos_q;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] daddr_q, daddr_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [15:0] pos_d;
  logic [15:0] l4_pos;

  // Field loads by position; the L4 offset uses the IHL held before this byte.
  always_comb begin
    l4_pos  = phcf_pkg::ETH_HDR_LEN + {10'b0, ihl_q, 2'b00};
    etype_d = etype_q;
    ihl_d   = ihl_q;
    proto_d = proto_q;
    daddr_d = daddr_q;
    sport_d = sport_q;
    dport_d = dport_q;
    if (pos_q == phcf_pkg::POS_ETYPE_HI || pos_q == phcf_pkg::POS_ETYPE_LO) begin
      etype_d = {etype_q[7:0], byte_i};
    end
    if (pos_q == phcf_pkg::POS_IHL) begin
      ihl_d = byte_i[3:0];
    end
    if (pos_q == phcf_pkg::POS_PROTO) begin
      proto_d = byte_i;
    end
    if (pos_q >= phcf_pkg::POS_DADDR_LO && pos_q <= phcf_pkg::POS_DADDR_HI) begin
      daddr_d = {daddr_q[23:0], byte_i};
    end
    if (pos_q == l4_pos || pos_q == l4_pos + 16'd1) begin
      sport_d = {sport_q[7:0], byte_i};
    end
    if (pos_q == l4_pos + 16'd2 || pos_q == l4_pos + 16'd3) begin
      dport_d = {dport_q[7:0], byte_i};
    end
    // Byte count saturates at the top of its range.
    pos_d = (pos_q == phcf_pkg::POS_MAX) ? pos_q : pos_q + 16'd1;
  end

  // Header view including the current byte.
  always_comb begin
    hdr_o.ether_type   = etype_d;
    hdr_o.header_words = ihl_d;
    hdr_o.ip_protocol  = proto_d;
    hdr_o.dest_address = daddr_d;
    hdr_o.udp_source   = sport_d;
    hdr_o.udp_dest     = dport_d;
    hdr_o.wire_length  = pos_d;
  end

  // Frame state advances on each beat and clears after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      etype_q <= '0;
      ihl_q   <= '0;
      proto_q <= '0;
      daddr_q <= '0;
      sport_q <= '0;
      dport_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        pos_q   <= '0;
        etype_q <= '0;
        ihl_q   <= '0;
        proto_q <= '0;
        daddr_q <= '0;
        sport_q <= '0;
        dport_q <= '0;
      end else begin
        pos_q   <= pos_d;
        etype_q <= etype_d;
        ihl_q   <= ihl_d;
        proto_q <= proto_d;
        daddr_q <= daddr_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- dv/packet_header_capture_filter_test.sv -----
// Self-checking testbench for the packet header capture filter: random and directed frames.
module packet_header_capture_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import phcf_pkg::*;

  // Cycles with no beat on any channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Highest register index; everything above the last real register is ignored.
  localparam logic [7:0] CFG_INDEX_MAX = 8'hFF;
  localparam int unsigned NUM_PHASES = 6;

  // One frame to be sent, described by its header fields.
  typedef struct {
    int unsigned len;
    logic [15:0] etype;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        raw;
    logic [7:0]  fill;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready_o;
  phcf_in_t  in_data = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  phcf_out_t out_data_o;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  packet_header_capture_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Byte beats waiting to be driven and verdicts waiting to come out.
  phcf_in_t  byte_beats[$];
  phcf_out_t expected_verdicts[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Mirror of the filter registers.
  logic [31:0] reg_meta_addr  = RST_METADATA_ADDR;
  logic [15:0] reg_dns_port   = RST_DNS_PORT;
  logic [15:0] reg_vxlan_dst  = RST_VXLAN_DST_PORT;
  logic [15:0] reg_vxlan_src  = RST_VXLAN_SRC_PORT;

  // Mirror of the per-frame header capture and the drop counters.
  logic [15:0] frame_pos   = '0;
  logic [15:0] seen_etype  = '0;
  logic [3:0]  seen_ihl    = '0;
  logic [7:0]  seen_proto  = '0;
  logic [31:0] seen_daddr  = '0;
  logic [15:0] seen_sport  = '0;
  logic [15:0] seen_dport  = '0;
  logic [63:0] drop_count[NUM_DROP_CNT] = '{default: '0};

  function automatic void apply_reg(logic [7:0] idx, logic [31:0] val);
    case (idx)
      CFG_METADATA_ADDR:  reg_meta_addr = val;
      CFG_DNS_PORT:       reg_dns_port  = val[15:0];
      CFG_VXLAN_DST_PORT: reg_vxlan_dst = val[15:0];
      CFG_VXLAN_SRC_PORT: reg_vxlan_src = val[15:0];
      default: ;
    endcase
  endfunction

  // Verdict for the frame just completed, checks in priority order.
  function automatic verdict_e judge_frame(int unsigned n, logic full);
    if (n < ETH_HDR_LEN) return VERDICT_BAD_HDR;
    if (seen_etype != ETYPE_IPV4) return VERDICT_NON_IPV4;
    if (n < MIN_IP_LEN) return VERDICT_BAD_HDR;
    if (seen_daddr == reg_meta_addr) return VERDICT_METADATA;
    if (seen_ihl < MIN_IHL) return VERDICT_BAD_HDR;
    if (seen_proto != PROTO_TCP && seen_proto != PROTO_UDP) return VERDICT_NON_L4;
    if (seen_proto == PROTO_UDP) begin
      if (n < ETH_HDR_LEN + 4 * seen_ihl + UDP_HDR_LEN) return VERDICT_BAD_HDR;
      if (seen_sport == reg_dns_port || seen_dport == reg_dns_port) return VERDICT_DNS;
      if (seen_sport == reg_vxlan_src || seen_dport == reg_vxlan_dst) return VERDICT_VXLAN;
    end
    if (full) return VERDICT_RING_FULL;
    return VERDICT_CAPTURED;
  endfunction

  // Advance the header capture by one accepted beat; queue a verdict on the last byte.
  function automatic void filter_beat(phcf_in_t beat);
    int unsigned pos;
    int unsigned l4;
    int unsigned n;
    int idx;
    verdict_e v;
    phcf_out_t res;
    pos = frame_pos;
    l4 = ETH_HDR_LEN + 4 * seen_ihl;
    if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) seen_etype = {seen_etype[7:0], beat.data_byte};
    if (pos == POS_IHL) seen_ihl = beat.data_byte[3:0];
    if (pos == POS_PROTO) seen_proto = beat.data_byte;
    if (pos >= POS_DADDR_LO && pos <= POS_DADDR_HI)
      seen_daddr = {seen_daddr[23:0], beat.data_byte};
    if (pos == l4 || pos == l4 + 1) seen_sport = {seen_sport[7:0], beat.data_byte};
    if (pos == l4 + 2 || pos == l4 + 3) seen_dport = {seen_dport[7:0], beat.data_byte};
    // The byte count saturates at the top of its range.
    n = (pos < POS_MAX) ? pos + 1 : POS_MAX;
    frame_pos = 16'(n);
    if (beat.last_byte) begin
      v = judge_frame(n, beat.ring_full);
      res.reason_count = '0;
      if (v >= VERDICT_NON_IPV4) begin
        idx = int'(v) - int'(VERDICT_NON_IPV4);
        drop_count[idx] = drop_count[idx] + 64'd1;
        res.reason_count = drop_count[idx];
      end
      res.verdict = v;
      res.wire_length = 16'(n);
      res.capture_length = 11'((n > CAPTURE_LIMIT) ? CAPTURE_LIMIT : n);
      res.direction_out = beat.ingress;
      res.interface_out = beat.interface_index;
      expected_verdicts.push_back(res);
      frame_pos = '0;
      seen_etype = '0;
      seen_ihl = '0;
      seen_proto = '0;
      seen_daddr = '0;
      seen_sport = '0;
      seen_dport = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Byte driver: presents the next queued beat unless it idles this cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) filter_beat(in_data);
      if (!in_valid || in_ready_o) begin
        if (byte_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= byte_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted verdict beat with the oldest expectation.
  always @(posedge clk_i) begin : verdict_monitor
    phcf_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict beat %p", $time, out_data_o);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("verdict", want.verdict, out_data_o.verdict);
          check_field("wire_length", want.wire_length, out_data_o.wire_length);
          check_field("capture_length", want.capture_length, out_data_o.capture_length);
          check_field("direction_out", want.direction_out, out_data_o.direction_out);
          check_field("interface_out", want.interface_out, out_data_o.interface_out);
          check_field("reason_count", want.reason_count, out_data_o.reason_count);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles in which no channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("FAIL packet_header_capture_filter");
    $finish;
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued byte is taken and every verdict has come out.
  task automatic wait_drained();
    while (byte_beats.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Expand a frame into byte beats; side fields matter only on the last byte.
  function automatic void queue_frame(frame_t f, logic ingress, logic [31:0] if_idx,
                                      logic full);
    int unsigned l4;
    phcf_in_t beat;
    l4 = ETH_HDR_LEN + 4 * f.ver_ihl[3:0];
    for (int unsigned p = 0; p < f.len; p++) begin
      beat.data_byte = f.raw ? f.fill : 8'($urandom);
      if (!f.raw) begin
        if (p == POS_ETYPE_HI) beat.data_byte = f.etype[15:8];
        if (p == POS_ETYPE_LO) beat.data_byte = f.etype[7:0];
        if (p == POS_IHL) beat.data_byte = f.ver_ihl;
        if (p == POS_PROTO) beat.data_byte = f.proto;
        if (p >= POS_DADDR_LO && p <= POS_DADDR_HI)
          beat.data_byte = f.daddr[8 * (POS_DADDR_HI - p) +: 8];
        if (f.ver_ihl[3:0] >= MIN_IHL) begin
          if (p == l4) beat.data_byte = f.sport[15:8];
          if (p == l4 + 1) beat.data_byte = f.sport[7:0];
          if (p == l4 + 2) beat.data_byte = f.dport[15:8];
          if (p == l4 + 3) beat.data_byte = f.dport[7:0];
        end
      end
      beat.last_byte = (p == f.len - 1);
      beat.ingress = beat.last_byte ? ingress : 1'($urandom);
      beat.interface_index = beat.last_byte ? if_idx : 32'($urandom);
      beat.ring_full = beat.last_byte ? full : 1'($urandom);
      byte_beats.push_back(beat);
    end
  endfunction

  function automatic frame_t base_frame(int unsigned len, logic [7:0] proto);
    frame_t f;
    f.len = len;
    f.etype = ETYPE_IPV4;
    f.ver_ihl = {4'h4, MIN_IHL};
    f.proto = proto;
    f.daddr = $urandom;
    f.sport = $urandom;
    f.dport = $urandom;
    f.raw = 1'b0;
    f.fill = '0;
    return f;
  endfunction

  // Ports lean toward the values that the filter looks for.
  function automatic logic [15:0] pick_port();
    case ($urandom_range(9))
      0, 1: return reg_dns_port;
      2: return reg_vxlan_src;
      3: return reg_vxlan_dst;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed IPv4 frames with random content; the rest cut short or malformed.
  function automatic frame_t random_frame();
    frame_t f;
    int unsigned ihl;
    int unsigned full_len;
    f = base_frame(0, PROTO_TCP);
    if ($urandom_range(99) < 10) f.etype = $urandom_range(1) ? 16'h86DD : 16'($urandom);
    case ($urandom_range(19))
      0: ihl = $urandom_range(4);
      1, 2: ihl = $urandom_range(15, 6);
      default: ihl = MIN_IHL;
    endcase
    f.ver_ihl = {4'($urandom), 4'(ihl)};
    case ($urandom_range(9))
      0, 1, 2, 3: f.proto = PROTO_UDP;
      4, 5, 6, 7: f.proto = PROTO_TCP;
      default: f.proto = 8'($urandom);
    endcase
    if ($urandom_range(9) == 0) f.daddr = reg_meta_addr;
    f.sport = pick_port();
    f.dport = pick_port();
    full_len = (ihl < MIN_IHL) ? MIN_IP_LEN : ETH_HDR_LEN + 4 * ihl + UDP_HDR_LEN;
    if ($urandom_range(99) < 70)
      f.len = full_len + $urandom_range(16);
    else
      f.len = $urandom_range(full_len, 1);
    return f;
  endfunction

  // Stimulus: directed frames, then random frames under several register settings.
  initial begin : stimulus
    frame_t f;
    int unsigned phase_bytes;
    int unsigned phase_frames;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 50 : 0;
      recv_idle_pct = (phase < 2) ? 50 : (phase < 4) ? 24 : 0;
      case (phase)
        0: begin
          // Directed frames under the reset register values.
          f = base_frame(1, PROTO_UDP);
          queue_frame(f, 1'b0, '0, 1'b0);
          f = base_frame(13, PROTO_UDP);
          queue_frame(f, 1'b1, '1, 1'b1);
          f = base_frame(14, PROTO_UDP);
          queue_frame(f, 1'b0, '1, 1'b0);
          f = base_frame(60, PROTO_UDP);
          f.etype = 16'h86DD;
          queue_frame(f, 1'b1, '0, 1'b1);
          f = base_frame(33, PROTO_TCP);
          queue_frame(f, 1'b0, $urandom, 1'b0);
          f = base_frame(34, PROTO_TCP);
          f.daddr = reg_meta_addr;
          queue_frame(f, 1'b1, $urandom, 1'b1);
          f = base_frame(34, PROTO_TCP);
          f.ver_ihl = {4'h4, 4'd4};
          queue_frame(f, 1'b0, $urandom, 1'b0);
          // Header length of zero puts the port bytes over the IP header.
          f = base_frame(40, PROTO_UDP);
          f.ver_ihl = 8'h40;
          queue_frame(f, 1'b1, $urandom, 1'b0);
          f = base_frame(50, 8'd1);
          queue_frame(f, 1'b0, $urandom, 1'b1);
          f = base_frame(41, PROTO_UDP);
          queue_frame(f, 1'b1, $urandom, 1'b0);
          f = base_frame(42, PROTO_UDP);
          queue_frame(f, 1'b0, $urandom, 1'b0);
          f = base_frame(42, PROTO_UDP);
          f.sport = reg_dns_port;
          queue_frame(f, 1'b1, $urandom, 1'b1);
          f = base_frame(42, PROTO_UDP);
          f.dport = reg_dns_port;
          queue_frame(f, 1'b0, $urandom, 1'b0);
          f = base_frame(42, PROTO_UDP);
          f.sport = reg_vxlan_src;
          queue_frame(f, 1'b1, $urandom, 1'b0);
          f = base_frame(42, PROTO_UDP);
          f.dport = reg_vxlan_dst;
          queue_frame(f, 1'b0, $urandom, 1'b1);
          // VXLAN ports on the wrong sides do not match.
          f = base_frame(42, PROTO_UDP);
          f.sport = reg_vxlan_dst;
          f.dport = reg_vxlan_src;
          queue_frame(f, 1'b1, $urandom, 1'b0);
          // TCP ignores the DNS port and reaches the ring check.
          f = base_frame(54, PROTO_TCP);
          f.sport = reg_dns_port;
          queue_frame(f, 1'b0, $urandom, 1'b1);
          f = base_frame(54, PROTO_TCP);
          queue_frame(f, 1'b1, $urandom, 1'b0);
          f = base_frame(82, PROTO_UDP);
          f.ver_ihl = 8'h4F;
          queue_frame(f, 1'b0, $urandom, 1'b0);
          f = base_frame(81, PROTO_UDP);
          f.ver_ihl = 8'h4F;
          queue_frame(f, 1'b1, $urandom, 1'b0);
          f = base_frame(64, PROTO_UDP);
          f.raw = 1'b1;
          f.fill = 8'h00;
          queue_frame(f, 1'b0, $urandom, 1'b0);
          f.fill = 8'hFF;
          queue_frame(f, 1'b1, $urandom, 1'b1);
          wait_drained();
        end
        1: begin
          write_reg(CFG_METADATA_ADDR, '0);
          write_reg(CFG_DNS_PORT, 32'hFFFF_0000);
          write_reg(CFG_VXLAN_DST_PORT, 32'h0000_FFFF);
          write_reg(CFG_VXLAN_SRC_PORT, '0);
          write_reg(CFG_INDEX_MAX, $urandom);
        end
        2: begin
          write_reg(CFG_METADATA_ADDR, '1);
          write_reg(CFG_DNS_PORT, '1);
          write_reg(CFG_VXLAN_DST_PORT, '0);
          write_reg(CFG_VXLAN_SRC_PORT, '1);
        end
        default: begin
          write_reg(CFG_METADATA_ADDR, $urandom);
          write_reg(CFG_DNS_PORT, $urandom);
          write_reg(CFG_VXLAN_DST_PORT, $urandom);
          write_reg(CFG_VXLAN_SRC_PORT, $urandom);
          write_reg(8'($urandom_range(CFG_INDEX_MAX, CFG_VXLAN_SRC_PORT + 1)), $urandom);
        end
      endcase
      phase_bytes = 0;
      phase_frames = 0;
      while (phase_bytes < 120 || phase_frames < 3) begin
        f = random_frame();
        queue_frame(f, 1'($urandom), $urandom, $urandom_range(99) < 15);
        phase_bytes += f.len;
        phase_frames++;
        // Hold the sender once mid-phase until every verdict is out.
        if (phase_frames == 2) wait_drained();
      end
      wait_drained();
    end
    repeat (8) @(negedge clk_i);
    if (mismatches == 0)
      $display("PASS packet_header_capture_filter");
    else
      $display("FAIL packet_header_capture_filter");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/phcf_pkg.sv
rtl/phcf_hdr_capture.sv
rtl/packet_header_capture_filter.sv
dv/packet_header_capture_filter_test.sv
